// File: hdl/isbn_pkg.sv
// shared types, constants and helpers of the image scaler
package isbn_pkg;

    typedef enum logic [2:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_STEP_X        = 3'd4,
        CFG_STEP_Y        = 3'd5,
        CFG_PIXEL_FORMAT  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_DIRECT  = 2'd1,
        OP_BLEND   = 2'd2,
        OP_NEAREST = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_MUL  = 2'd1,
        F_PUSH = 2'd2
    } fst_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_RUN  = 2'd1,
        B_WAIT = 2'd2,
        B_OUT  = 2'd3
    } bst_t;

    typedef struct packed {
        logic [8:0]  source_width;
        logic [8:0]  source_height;
        logic [12:0] target_width;
        logic [12:0] target_height;
        logic [24:0] step_x;
        logic [24:0] step_y;
        logic        pixel_format;
    } cfg_t;

    localparam logic        KIND_STORE  = 1'b0;
    localparam logic        FMT_ARGB1555 = 1'b1;
    localparam logic [31:0] AG_MASK     = 32'hFF00FF00;
    localparam logic [31:0] RB_MASK     = 32'h00FF00FF;
    localparam logic [9:0]  WEIGHT_ONE  = 10'd256;
    localparam logic [37:0] HALF_PIXEL  = 38'd32768;

    function automatic logic [31:0] expand1555(input logic [15:0] c);
        logic [31:0] r;
        r = c[15] ? 32'hff000000 : 32'h0;
        r = r | ({17'b0, c[14:10], 10'b0} << 9)
              | ({22'b0, c[9:5], 5'b0} << 6)
              | ({27'b0, c[4:0]} << 3);
        return r;
    endfunction

endpackage

// File: hdl/isbn_front.sv
// front end: accepts items, works out source addresses and weights, queues commands
module isbn_front #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096,
    parameter int XW             = 8,
    parameter int YW             = 8,
    parameter int CW             = 2 + 4 * 16 + 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isbn_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [11:0]          coord_x,
    input  logic [11:0]          coord_y,
    input  logic [31:0]          pixel_value,
    output logic                 push,
    output logic [CW-1:0]        push_data,
    input  logic                 full
);

    localparam int AW = XW + YW;

    typedef struct packed {
        isbn_pkg::op_t op;
        logic [AW-1:0] a0;
        logic [AW-1:0] a1;
        logic [AW-1:0] a2;
        logic [AW-1:0] a3;
        logic [7:0]    u;
        logic [7:0]    v;
        logic [31:0]   data;
    } cmd_t;

    isbn_pkg::fst_t state_reg, state_next;

    logic        kind_reg;
    logic [11:0] cx_reg;
    logic [11:0] cy_reg;
    logic [31:0] pv_reg;
    logic [36:0] px_reg;
    logic [36:0] py_reg;

    logic [15:0] sw, sh, tw, th, sw_m1, sh_m1;
    logic [37:0] bxs, bys;
    logic [21:0] bx, by, swm, shm, x0w, x1w, y0w, y1w, nxw, nyw;
    logic [XW-1:0] x0, x1, cxi;
    logic [YW-1:0] y0, y1, cyi;
    logic        keep;
    cmd_t        cmd;

    always_comb
    begin
        sw = {7'b0, cfg.source_width};
        if (sw == 16'd0) sw = 16'd1;
        if (sw > 16'(MAX_SRC_WIDTH)) sw = 16'(MAX_SRC_WIDTH);
        sh = {7'b0, cfg.source_height};
        if (sh == 16'd0) sh = 16'd1;
        if (sh > 16'(MAX_SRC_HEIGHT)) sh = 16'(MAX_SRC_HEIGHT);
        tw = {3'b0, cfg.target_width};
        if (tw == 16'd0) tw = 16'd1;
        if (tw > 16'(MAX_DST_DIM)) tw = 16'(MAX_DST_DIM);
        th = {3'b0, cfg.target_height};
        if (th == 16'd0) th = 16'd1;
        if (th > 16'(MAX_DST_DIM)) th = 16'(MAX_DST_DIM);
        sw_m1 = sw - 16'd1;
        sh_m1 = sh - 16'd1;
        swm = {6'b0, sw_m1};
        shm = {6'b0, sh_m1};
    end

    // source position with half-pixel offset, biased by one pixel
    always_comb
    begin
        bxs = {1'b0, px_reg} + {14'b0, cfg.step_x[24:1]} + isbn_pkg::HALF_PIXEL;
        bys = {1'b0, py_reg} + {14'b0, cfg.step_y[24:1]} + isbn_pkg::HALF_PIXEL;
        bx  = bxs[37:16];
        by  = bys[37:16];
        x1w = (bx < swm) ? bx : swm;
        y1w = (by < shm) ? by : shm;
        x0w = (bx == 22'd0) ? 22'd0 : (((bx - 22'd1) < swm) ? (bx - 22'd1) : swm);
        y0w = (by == 22'd0) ? 22'd0 : (((by - 22'd1) < shm) ? (by - 22'd1) : shm);
        nxw = ({1'b0, px_reg[36:16]} < swm) ? {1'b0, px_reg[36:16]} : swm;
        nyw = ({1'b0, py_reg[36:16]} < shm) ? {1'b0, py_reg[36:16]} : shm;
        x0  = x0w[XW-1:0];
        x1  = x1w[XW-1:0];
        y0  = y0w[YW-1:0];
        y1  = y1w[YW-1:0];
        cxi = cx_reg[XW-1:0];
        cyi = cy_reg[YW-1:0];
    end

    always_comb
    begin
        cmd.op   = isbn_pkg::OP_WRITE;
        cmd.a0   = {cyi, cxi};
        cmd.a1   = {y0, x1};
        cmd.a2   = {y1, x0};
        cmd.a3   = {y1, x1};
        cmd.u    = bxs[15:8];
        cmd.v    = bys[15:8];
        cmd.data = pv_reg;
        keep     = 1'b0;
        if (kind_reg == isbn_pkg::KIND_STORE)
        begin
            keep = ({4'b0, cx_reg} < 16'(MAX_SRC_WIDTH))
                && ({4'b0, cy_reg} < 16'(MAX_SRC_HEIGHT));
        end
        else if (({4'b0, cx_reg} < tw) && ({4'b0, cy_reg} < th))
        begin
            keep = 1'b1;
            if (cfg.pixel_format == isbn_pkg::FMT_ARGB1555)
            begin
                cmd.op = isbn_pkg::OP_NEAREST;
                cmd.a0 = {nyw[YW-1:0], nxw[XW-1:0]};
            end
            else if (sw == tw && sh == th)
            begin
                cmd.op = isbn_pkg::OP_DIRECT;
            end
            else
            begin
                cmd.op = isbn_pkg::OP_BLEND;
                cmd.a0 = {y0, x0};
            end
        end
        push_data = CW'(cmd);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isbn_pkg::F_IDLE: if (in_valid) state_next = isbn_pkg::F_MUL;
            isbn_pkg::F_MUL:  state_next = isbn_pkg::F_PUSH;
            isbn_pkg::F_PUSH: if (!keep || !full) state_next = isbn_pkg::F_IDLE;
            default:          state_next = isbn_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != isbn_pkg::F_IDLE);
        push     = (state_reg == isbn_pkg::F_PUSH) && keep && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isbn_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == isbn_pkg::F_IDLE && in_valid)
        begin
            kind_reg <= kind;
            cx_reg   <= coord_x;
            cy_reg   <= coord_y;
            pv_reg   <= pixel_value;
        end
        if (state_reg == isbn_pkg::F_MUL)
        begin
            px_reg <= {25'b0, cx_reg} * {12'b0, cfg.step_x};
            py_reg <= {25'b0, cy_reg} * {12'b0, cfg.step_y};
        end
    end

endmodule

// File: hdl/isbn_queue.sv
// short command queue between front and back end
module isbn_queue #(
    parameter int CW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [CW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic [CW-1:0] pop_data,
    output logic          empty
);

    localparam int DEPTH = 4;

    logic [CW-1:0] mem_reg [DEPTH];
    logic [1:0]    wptr_reg, rptr_reg;
    logic [2:0]    count_reg;

    assign full     = (count_reg == 3'(DEPTH));
    assign empty    = (count_reg == 3'd0);
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            if (push) wptr_reg <= wptr_reg + 2'd1;
            if (pop)  rptr_reg <= rptr_reg + 2'd1;
            if (push && !pop)      count_reg <= count_reg + 3'd1;
            else if (pop && !push) count_reg <= count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wptr_reg] <= push_data;
    end

endmodule

// File: hdl/isbn_back.sv
// back end: pixel store, neighbour reads, blend or expand, output register
module isbn_back #(
    parameter int XW = 8,
    parameter int YW = 8,
    parameter int CW = 2 + 4 * 16 + 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [CW-1:0] cmd_data,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [31:0]   color
);

    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    typedef struct packed {
        isbn_pkg::op_t op;
        logic [AW-1:0] a0;
        logic [AW-1:0] a1;
        logic [AW-1:0] a2;
        logic [AW-1:0] a3;
        logic [7:0]    u;
        logic [7:0]    v;
        logic [31:0]   data;
    } cmd_t;

    isbn_pkg::bst_t state_reg, state_next;

    cmd_t        cmd_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  ph_reg;
    logic        pend_reg;
    logic [7:0]  w3_reg;
    logic [31:0] ag_reg, rb_reg;
    logic [31:0] rdata_reg;
    logic        out_valid_reg;
    logic [31:0] color_reg;
    logic [31:0] mem [DEPTH];

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic          last;
    logic          can_load;
    logic [8:0]    w0, w1, w2, w;
    logic [31:0]   ag_prod, rb_prod, result;

    assign out_valid = out_valid_reg;
    assign color     = color_reg;
    assign can_load  = !out_valid_reg || !out_stall;
    assign last      = (cmd_reg.op != isbn_pkg::OP_BLEND) || (cnt_reg == 2'd3);

    always_comb
    begin
        w2 = {1'b0, cmd_reg.u} - {1'b0, w3_reg};
        w1 = {1'b0, cmd_reg.v} - {1'b0, w3_reg};
        w0 = 9'(isbn_pkg::WEIGHT_ONE - {1'b0, w1} - {1'b0, w2} - {2'b0, w3_reg});
        case (ph_reg)
            2'd0:    w = w0;
            2'd1:    w = w2;
            2'd2:    w = w1;
            default: w = {1'b0, w3_reg};
        endcase
        ag_prod = ((rdata_reg & isbn_pkg::AG_MASK) >> 8) * {23'b0, w};
        rb_prod = (rdata_reg & isbn_pkg::RB_MASK) * {23'b0, w};
        case (cmd_reg.op)
            isbn_pkg::OP_BLEND:
                result = (ag_reg & isbn_pkg::AG_MASK) | ((rb_reg & isbn_pkg::AG_MASK) >> 8);
            isbn_pkg::OP_NEAREST:
                result = isbn_pkg::expand1555(rdata_reg[15:0]);
            default:
                result = rdata_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isbn_pkg::B_IDLE: if (!empty) state_next = isbn_pkg::B_RUN;
            isbn_pkg::B_RUN:
            begin
                if (cmd_reg.op == isbn_pkg::OP_WRITE) state_next = isbn_pkg::B_IDLE;
                else if (last)                        state_next = isbn_pkg::B_WAIT;
            end
            isbn_pkg::B_WAIT: state_next = isbn_pkg::B_OUT;
            isbn_pkg::B_OUT:  if (can_load) state_next = isbn_pkg::B_IDLE;
            default:          state_next = isbn_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop    = (state_reg == isbn_pkg::B_IDLE) && !empty;
        mem_we = (state_reg == isbn_pkg::B_RUN) && (cmd_reg.op == isbn_pkg::OP_WRITE);
        mem_re = (state_reg == isbn_pkg::B_RUN) && (cmd_reg.op != isbn_pkg::OP_WRITE);
        case (cnt_reg)
            2'd0:    mem_addr = cmd_reg.a0;
            2'd1:    mem_addr = cmd_reg.a1;
            2'd2:    mem_addr = cmd_reg.a2;
            default: mem_addr = cmd_reg.a3;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isbn_pkg::B_IDLE;
            cnt_reg       <= 2'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= mem_re;
            if (pop)         cnt_reg <= 2'd0;
            else if (mem_re) cnt_reg <= cnt_reg + 2'd1;
            if (state_reg == isbn_pkg::B_OUT && can_load) out_valid_reg <= 1'b1;
            else if (!out_stall)                          out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cmd_t'(cmd_data);
            ag_reg  <= 32'd0;
            rb_reg  <= 32'd0;
        end
        else if (pend_reg)
        begin
            ag_reg <= ag_reg + ag_prod;
            rb_reg <= rb_reg + rb_prod;
        end
        if (mem_re)
        begin
            ph_reg <= cnt_reg;
        end
        if (state_reg == isbn_pkg::B_RUN && cnt_reg == 2'd0)
        begin
            w3_reg <= 8'(({8'b0, cmd_reg.u} * {8'b0, cmd_reg.v}) >> 8);
        end
        if (state_reg == isbn_pkg::B_OUT && can_load)
        begin
            color_reg <= result;
        end
    end

    // single-port pixel store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= cmd_reg.data;
        end
        else if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

endmodule

// File: hdl/image_scaler_bilinear_nearest_core.sv
// top level of the bilinear / nearest image scaler
// an item passes the front end's multiply and push states, and then the next one is accepted
// a queued render transaction passes the back end's run, wait and out states
// back end: a bilinear render reads its four neighbours from the single-port store in turn
// nearest and direct commands make a single read of the store, a store command a single write
// reset sets control and config registers; data and pixel store hold garbage until written
module image_scaler_bilinear_nearest_core #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [24:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [11:0] coord_x,
    input  logic [11:0] coord_y,
    input  logic [31:0] pixel_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] color
);

    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int CW = 2 + 4 * (XW + YW) + 48;

    isbn_pkg::cfg_t cfg_reg;
    logic           push, pop, full, empty;
    logic [CW-1:0]  push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= 9'd256;
            cfg_reg.source_height <= 9'd256;
            cfg_reg.target_width  <= 13'd256;
            cfg_reg.target_height <= 13'd256;
            cfg_reg.step_x        <= 25'd65537;
            cfg_reg.step_y        <= 25'd65537;
            cfg_reg.pixel_format  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (isbn_pkg::cfg_idx_t'(cfg_index))
                isbn_pkg::CFG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data[8:0];
                isbn_pkg::CFG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data[8:0];
                isbn_pkg::CFG_TARGET_WIDTH:  cfg_reg.target_width  <= cfg_data[12:0];
                isbn_pkg::CFG_TARGET_HEIGHT: cfg_reg.target_height <= cfg_data[12:0];
                isbn_pkg::CFG_STEP_X:        cfg_reg.step_x        <= cfg_data;
                isbn_pkg::CFG_STEP_Y:        cfg_reg.step_y        <= cfg_data;
                isbn_pkg::CFG_PIXEL_FORMAT:  cfg_reg.pixel_format  <= cfg_data[0];
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    isbn_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_DIM    (MAX_DST_DIM),
        .XW             (XW),
        .YW             (YW),
        .CW             (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .pixel_value (pixel_value),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    isbn_queue #(
        .CW (CW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    isbn_back #(
        .XW (XW),
        .YW (YW),
        .CW (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (pop_data),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .color     (color)
    );

endmodule

// File: sim/image_scaler_bilinear_nearest_core_test.sv
// testbench of the bilinear / nearest image scaler core with its own color predictor
module image_scaler_bilinear_nearest_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_RENDER  = 1'b1;
    localparam logic FMT_ARGB8888 = 1'b0;
    localparam int SRC_MAX = 256;
    localparam int DST_MAX = 4096;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    isbn_pkg::cfg_idx_t  cfg_index = isbn_pkg::CFG_SOURCE_WIDTH;
    logic [24:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                kind = isbn_pkg::KIND_STORE;
    logic [11:0]         coord_x = '0;
    logic [11:0]         coord_y = '0;
    logic [31:0]         pixel_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [31:0]         color;

    image_scaler_bilinear_nearest_core uut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] pixel_mem [0:SRC_MAX*SRC_MAX-1];
    bit          pixel_set [0:SRC_MAX*SRC_MAX-1];
    logic [8:0]  src_w = 9'd256;
    logic [8:0]  src_h = 9'd256;
    logic [12:0] dst_w = 13'd256;
    logic [12:0] dst_h = 13'd256;
    logic [24:0] step_x = 25'd65537;
    logic [24:0] step_y = 25'd65537;
    logic        fmt = FMT_ARGB8888;

    logic [31:0] expected_colors [$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    longint      cycles = 0;
    int          stall_hold = 0;
    int          sent = 0;

    function automatic int sat(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint clampi(input longint v, input longint size);
        if (v < 0) return 0;
        if (v >= size) return size - 1;
        return v;
    endfunction

    function automatic logic [31:0] fetch(input longint x, input longint y, inout bit ok);
        int a;
        a = int'(y) * SRC_MAX + int'(x);
        if (!pixel_set[a]) ok = 1'b0;
        return pixel_mem[a];
    endfunction

    function automatic void locate(input int d, input logic [24:0] step,
                                   output longint ip, output int unsigned frac);
        longint biased;
        biased = (longint'(step >> 1) - 32768) + longint'(d) * longint'(step) + 65536;
        ip = (biased >>> 16) - 1;
        frac = int'((biased & 64'hFFFF) >> 8);
    endfunction

    function automatic logic [31:0] blend4(input logic [31:0] p [4],
                                           input int unsigned u, input int unsigned v);
        int unsigned w [4];
        logic [31:0] ag, rb;
        w[3] = (u * v) >> 8;
        w[1] = u - w[3];
        w[2] = v - w[3];
        w[0] = 256 - w[1] - w[2] - w[3];
        ag = 0;
        rb = 0;
        for (int i = 0; i < 4; i++)
        begin
            ag += ((p[i] & isbn_pkg::AG_MASK) >> 8) * w[i];
            rb += (p[i] & isbn_pkg::RB_MASK) * w[i];
        end
        return (ag & isbn_pkg::AG_MASK) | ((rb & isbn_pkg::AG_MASK) >> 8);
    endfunction

    // returns 0 when the render would read a pixel never stored
    function automatic bit scaled_color(input int cx, input int cy,
                                        output bit has, output logic [31:0] c);
        int sw, sh, tw, th;
        longint ix, iy, x0, x1, y0, y1, nx, ny;
        int unsigned u, v;
        logic [31:0] p [4];
        logic [31:0] q;
        logic [15:0] s;
        bit ok;
        ok = 1'b1;
        has = 1'b0;
        c = '0;
        sw = sat(src_w, SRC_MAX);
        sh = sat(src_h, SRC_MAX);
        tw = sat(dst_w, DST_MAX);
        th = sat(dst_h, DST_MAX);
        if (cx >= tw || cy >= th) return 1'b1;
        has = 1'b1;
        if (fmt == FMT_ARGB8888)
        begin
            if (sw == tw && sh == th)
                c = fetch(cx, cy, ok);
            else
            begin
                locate(cx, step_x, ix, u);
                locate(cy, step_y, iy, v);
                x0 = clampi(ix, sw);
                x1 = clampi(ix + 1, sw);
                y0 = clampi(iy, sh);
                y1 = clampi(iy + 1, sh);
                p[0] = fetch(x0, y0, ok);
                p[1] = fetch(x1, y0, ok);
                p[2] = fetch(x0, y1, ok);
                p[3] = fetch(x1, y1, ok);
                c = blend4(p, u, v);
            end
        end
        else
        begin
            nx = clampi((longint'(cx) * longint'(step_x)) >>> 16, sw);
            ny = clampi((longint'(cy) * longint'(step_y)) >>> 16, sh);
            q = fetch(nx, ny, ok);
            s = q[15:0];
            c = (s[15] ? 32'hff000000 : 32'h0) | ({17'b0, s[14:10]} << 19)
                | ({22'b0, s[9:5]} << 11) | ({27'b0, s[4:0]} << 3);
        end
        return ok;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_colors.size() == 0)
            begin
                $error("unexpected transaction: color actual %h", color);
                failed = 1'b1;
            end
            else
            begin
                if (color !== expected_colors[0])
                begin
                    $error("color expected %h actual %h", expected_colors[0], color);
                    failed = 1'b1;
                end
                void'(expected_colors.pop_front());
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_hold > 0)
            stall_hold--;
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= ~out_stall;
            stall_hold = $urandom_range(1, 17);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("image_scaler_bilinear_nearest_core test failed");
            $finish;
        end
    end

    task automatic send_item(input logic k, input int x, input int y, input logic [31:0] pv);
        bit has, ok, st;
        logic [31:0] c;
        has = 1'b0;
        c = '0;
        if (k == KIND_RENDER)
        begin
            ok = scaled_color(x, y, has, c);
            if (!ok) return;
        end
        in_valid <= 1'b1;
        kind <= k;
        coord_x <= x[11:0];
        coord_y <= y[11:0];
        pixel_value <= pv;
        do
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
        end while (st);
        sent++;
        if (k == isbn_pkg::KIND_STORE && x < SRC_MAX && y < SRC_MAX)
        begin
            pixel_mem[y * SRC_MAX + x] = pv;
            pixel_set[y * SRC_MAX + x] = 1'b1;
        end
        if (has) expected_colors.push_back(c);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_reg(input isbn_pkg::cfg_idx_t idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[24:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            isbn_pkg::CFG_SOURCE_WIDTH:  src_w = value[8:0];
            isbn_pkg::CFG_SOURCE_HEIGHT: src_h = value[8:0];
            isbn_pkg::CFG_TARGET_WIDTH:  dst_w = value[12:0];
            isbn_pkg::CFG_TARGET_HEIGHT: dst_h = value[12:0];
            isbn_pkg::CFG_STEP_X:        step_x = value[24:0];
            isbn_pkg::CFG_STEP_Y:        step_y = value[24:0];
            default:                     fmt = value[0];
        endcase
    endtask

    task automatic configure(input int sw, input int sh, input int tw, input int th,
                             input int unsigned sx, input int unsigned sy, input logic f);
        drain(12);
        set_reg(isbn_pkg::CFG_SOURCE_WIDTH, sw);
        set_reg(isbn_pkg::CFG_SOURCE_HEIGHT, sh);
        set_reg(isbn_pkg::CFG_TARGET_WIDTH, tw);
        set_reg(isbn_pkg::CFG_TARGET_HEIGHT, th);
        set_reg(isbn_pkg::CFG_STEP_X, sx);
        set_reg(isbn_pkg::CFG_STEP_Y, sy);
        set_reg(isbn_pkg::CFG_PIXEL_FORMAT, f);
    endtask

    function automatic int unsigned fit_step(input int s, input int t);
        return ((sat(s, SRC_MAX) << 16) / sat(t, DST_MAX)) + 1;
    endfunction

    task automatic fill_source();
        for (int y = 0; y < sat(src_h, SRC_MAX); y++)
            for (int x = 0; x < sat(src_w, SRC_MAX); x++)
                send_item(isbn_pkg::KIND_STORE, x, y, $urandom());
    endtask

    task automatic test_direct_copy();
        configure(256, 256, 256, 256, 65537, 65537, FMT_ARGB8888);
        send_item(isbn_pkg::KIND_STORE, 0, 0, 32'h0);
        send_item(isbn_pkg::KIND_STORE, 255, 255, 32'hFFFFFFFF);
        send_item(isbn_pkg::KIND_STORE, 255, 0, 32'hA5A5A5A5);
        send_item(isbn_pkg::KIND_STORE, 4095, 4095, 32'h5A5A5A5A);
        send_item(isbn_pkg::KIND_STORE, 300, 7, 32'h12345678);
        send_item(KIND_RENDER, 0, 0, 32'hFFFFFFFF);
        send_item(KIND_RENDER, 255, 255, 32'h0);
        send_item(KIND_RENDER, 255, 0, 32'h0);
        send_item(KIND_RENDER, 256, 0, 32'h0);
        send_item(KIND_RENDER, 4095, 4095, 32'h0);
    endtask

    task automatic test_bilinear_edges();
        configure(4, 3, 7, 5, fit_step(4, 7), fit_step(3, 5), FMT_ARGB8888);
        fill_source();
        send_item(KIND_RENDER, 0, 0, 0);
        send_item(KIND_RENDER, 6, 4, 0);
        send_item(KIND_RENDER, 6, 0, 0);
        send_item(KIND_RENDER, 3, 2, 0);
        send_item(KIND_RENDER, 7, 1, 0);
    endtask

    task automatic test_nearest_expand();
        configure(4, 3, 9, 9, 25'h1FFFFFF, 0, isbn_pkg::FMT_ARGB1555);
        send_item(isbn_pkg::KIND_STORE, 0, 0, 32'h0000FFFF);
        send_item(isbn_pkg::KIND_STORE, 3, 0, 32'hFFFF7FFF);
        send_item(KIND_RENDER, 0, 0, 0);
        send_item(KIND_RENDER, 8, 8, 0);
        send_item(KIND_RENDER, 9, 0, 0);
    endtask

    task automatic test_size_saturation();
        configure(0, 511, 0, 8191, 0, 25'h1FFFFFF, FMT_ARGB8888);
        send_item(KIND_RENDER, 0, 0, 0);
        send_item(KIND_RENDER, 1, 0, 0);
        send_item(KIND_RENDER, 0, 4095, 0);
    endtask

    task automatic random_phase(input int items, input bit pause);
        int sw, sh, tw, th, r;
        int unsigned sx, sy;
        logic f;
        sw = $urandom_range(1, 12);
        sh = $urandom_range(1, 8);
        r = $urandom_range(0, 9);
        if (r == 0) sw = $urandom_range(0, 511);
        if (r == 1) sh = $urandom_range(0, 3);
        tw = ($urandom_range(0, 3) == 0) ? sw : $urandom_range(1, 24);
        th = ($urandom_range(0, 3) == 0) ? sh : $urandom_range(1, 24);
        if ($urandom_range(0, 9) == 0) tw = $urandom_range(0, 8191);
        if ($urandom_range(0, 9) == 0) th = $urandom_range(0, 8191);
        sx = fit_step(sw, tw);
        sy = fit_step(sh, th);
        if ($urandom_range(0, 7) == 0) sx = $urandom_range(0, 25'h1FFFFFF);
        if ($urandom_range(0, 7) == 0) sy = $urandom_range(0, 3);
        f = $urandom_range(0, 1);
        configure(sw, sh, tw, th, sx, sy, f);
        if (sat(src_w, SRC_MAX) * sat(src_h, SRC_MAX) > 300)
            set_reg(isbn_pkg::CFG_SOURCE_HEIGHT, 1);
        fill_source();
        for (int i = 0; i < items; i++)
        begin
            if (pause && i == items / 2)
                drain(0);
            r = $urandom_range(0, 9);
            if (r == 0)
                send_item(isbn_pkg::KIND_STORE, $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom());
            else if (r == 1)
                send_item(isbn_pkg::KIND_STORE, $urandom_range(0, sat(src_w, SRC_MAX) - 1),
                          $urandom_range(0, sat(src_h, SRC_MAX) - 1), $urandom());
            else if (r == 2)
                send_item(KIND_RENDER, $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
            else
                send_item(KIND_RENDER, $urandom_range(0, sat(dst_w, DST_MAX) - 1),
                          $urandom_range(0, sat(dst_h, DST_MAX) - 1), $urandom());
        end
    endtask

    task automatic test_random_scaling();
        int n;
        n = 0;
        while (sent < 1300)
        begin
            random_phase($urandom_range(20, 50), n == 3);
            n++;
        end
        quiet = 1'b1;
        random_phase(60, 1'b0);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_direct_copy();
        test_bilinear_edges();
        test_nearest_expand();
        test_size_saturation();
        test_random_scaling();
        drain(20);
        if (!failed)
            $display("image_scaler_bilinear_nearest_core test passed");
        else
            $display("image_scaler_bilinear_nearest_core test failed");
        $finish;
    end
endmodule
